FILE: src/asd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package asd_pkg;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_HEADER = 2'd1,
      ST_BAD_MAGIC  = 2'd2,
      ST_TRUNCATED  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       starts_file;
      logic       ends_file;
   } req_type;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic        frame_start;
      logic        frame_end;
      logic [3:0]  frame_type;
      logic        wideband;
      logic [31:0] time_ms;
      logic [1:0]  status;
   } rsp_type;

   // classified byte handed from the parser to the output side
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       frame_end;
      logic [3:0] frame_type;
      logic       wideband;
      logic       stamped;
      logic       restart;
      status_type status;
   } rec_type;

   localparam int MagicLen = 9;
   localparam logic [3:0] NbMagicSplit = 4'd5;
   localparam logic [3:0] WbMagicLast  = 4'd8;

   localparam logic [7:0] MAGIC_TEXT [MagicLen] = '{
      8'h23, 8'h21, 8'h41, 8'h4d, 8'h52, 8'h2d, 8'h57, 8'h42, 8'h0a
   };
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_DASH    = 8'h2d;

   localparam logic [8:0] NB_BITS [8] = '{
      9'd95, 9'd103, 9'd118, 9'd134, 9'd148, 9'd159, 9'd204, 9'd244
   };
   localparam logic [8:0] WB_BITS [9] = '{
      9'd132, 9'd177, 9'd253, 9'd285, 9'd317, 9'd365, 9'd397, 9'd461, 9'd477
   };

   localparam logic [7:0]  HDR_PAD_MASK = 8'h83;
   localparam logic [3:0]  MAX_NB_TYPE  = 4'd7;
   localparam logic [3:0]  MAX_WB_TYPE  = 4'd8;
   localparam logic [31:0] FRAME_MS     = 32'd20;

   function automatic logic [7:0] magic_char(input logic [3:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      if (pos < 4'(MagicLen)) begin
         ch = MAGIC_TEXT[pos];
      end
      return ch;
   endfunction

   // bytes after the header: ceil(bits / 8)
   function automatic logic [5:0] body_len(input logic wb, input logic [3:0] ft);
      logic [8:0] bits;
      logic [9:0] sum;
      bits = 9'd0;
      if (wb) begin
         if (ft <= MAX_WB_TYPE) begin
            bits = WB_BITS[ft];
         end
      end else begin
         bits = NB_BITS[ft[2:0]];
      end
      sum = {1'b0, bits} + 10'd7;
      return sum[8:3];
   endfunction

endpackage

`default_nettype wire

FILE: src/asd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module asd_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  asd_pkg::req_type req_payload,
   input  logic            queue_full,
   output logic            push,
   output asd_pkg::rec_type push_rec
);
   import asd_pkg::*;

   typedef enum logic [6:0] {
      PH_MAGIC   = 7'b0000001,
      PH_HEADER  = 7'b0000010,
      PH_BODY    = 7'b0000100,
      PH_DONE    = 7'b0001000,
      PH_ERR_HDR = 7'b0010000,
      PH_ERR_MAG = 7'b0100000,
      PH_ERR_TRN = 7'b1000000
   } phase_type;

   phase_type  phase_ff, phase_in, phase_e;
   logic [3:0] pos_ff, pos_in, pos_e;
   logic       wb_ff, wb_in, wb_e;
   logic [5:0] left_ff, left_in, left_e, left_dec;
   logic [3:0] type_ff, type_in, type_e;
   logic       pend_ff, pend_in, restart_e;
   logic       accept, emit, ok, done, done_wb, bad_hdr;
   logic [7:0] b;
   logic [3:0] ft;
   rec_type    rec;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_payload.data_byte;
   assign ft        = b[6:3];

   // a file start wipes the parser before the byte is looked at
   always_comb begin
      phase_e   = req_payload.starts_file ? PH_MAGIC : phase_ff;
      pos_e     = req_payload.starts_file ? 4'd0 : pos_ff;
      wb_e      = req_payload.starts_file ? 1'b0 : wb_ff;
      left_e    = req_payload.starts_file ? 6'd0 : left_ff;
      type_e    = req_payload.starts_file ? 4'd0 : type_ff;
      restart_e = req_payload.starts_file | pend_ff;
   end

   always_comb begin
      phase_in = phase_e;
      pos_in   = pos_e;
      wb_in    = wb_e;
      left_in  = left_e;
      type_in  = type_e;
      emit     = 1'b0;
      ok       = 1'b0;
      done     = 1'b0;
      done_wb  = 1'b0;
      left_dec = left_e - 6'd1;
      bad_hdr  = ((b & HDR_PAD_MASK) != 8'h00) || (ft > MAX_WB_TYPE) ||
                 (!wb_e && (ft > MAX_NB_TYPE));
      rec      = '0;
      rec.data_byte = b;
      rec.status    = ST_OK;
      unique case (phase_e)
         PH_MAGIC: begin
            if (pos_e == NbMagicSplit) begin
               if (b == CHAR_NEWLINE) begin
                  ok   = 1'b1;
                  done = 1'b1;
               end else begin
                  ok = (b == CHAR_DASH);
               end
            end else if (pos_e < 4'(MagicLen)) begin
               ok = (b == magic_char(pos_e));
               if (ok && pos_e == WbMagicLast) begin
                  done    = 1'b1;
                  done_wb = 1'b1;
               end
            end
            if (!ok || (req_payload.ends_file && !done)) begin
               phase_in   = PH_ERR_MAG;
               emit       = 1'b1;
               rec.status = ST_BAD_MAGIC;
            end else if (done) begin
               wb_in    = done_wb;
               phase_in = req_payload.ends_file ? PH_DONE : PH_HEADER;
            end else begin
               pos_in = pos_e + 4'd1;
            end
         end
         PH_HEADER: begin
            emit = 1'b1;
            if (bad_hdr) begin
               phase_in   = PH_ERR_HDR;
               rec.status = ST_BAD_HEADER;
            end else begin
               type_in         = ft;
               left_in         = body_len(wb_e, ft);
               rec.frame_start = 1'b1;
               rec.frame_type  = ft;
               rec.wideband    = wb_e;
               rec.stamped     = 1'b1;
               if (req_payload.ends_file) begin
                  phase_in   = PH_ERR_TRN;
                  rec.status = ST_TRUNCATED;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            emit           = 1'b1;
            left_in        = left_dec;
            rec.frame_type = type_e;
            rec.wideband   = wb_e;
            rec.stamped    = 1'b1;
            if (left_dec == 6'd0) begin
               rec.frame_end = 1'b1;
               phase_in      = req_payload.ends_file ? PH_DONE : PH_HEADER;
            end else if (req_payload.ends_file) begin
               rec.status = ST_TRUNCATED;
               phase_in   = PH_ERR_TRN;
            end
         end
         PH_ERR_HDR: begin
            emit          = 1'b1;
            rec.data_byte = 8'h00;
            rec.status    = ST_BAD_HEADER;
         end
         PH_ERR_MAG: begin
            emit          = 1'b1;
            rec.data_byte = 8'h00;
            rec.status    = ST_BAD_MAGIC;
         end
         PH_ERR_TRN: begin
            emit          = 1'b1;
            rec.data_byte = 8'h00;
            rec.status    = ST_TRUNCATED;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      rec.restart = restart_e;
      // the time base restart rides on the next request that makes output
      pend_in     = emit ? 1'b0 : restart_e;
   end

   assign push     = accept && emit;
   assign push_rec = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC;
         pos_ff   <= 4'd0;
         wb_ff    <= 1'b0;
         left_ff  <= 6'd0;
         type_ff  <= 4'd0;
         pend_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         wb_ff    <= wb_in;
         left_ff  <= left_in;
         type_ff  <= type_in;
         pend_ff  <= pend_in;
      end
   end

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && !req_payload.starts_file &&
      (phase_ff == PH_ERR_HDR || phase_ff == PH_ERR_MAG || phase_ff == PH_ERR_TRN)
      |-> push && push_rec.status != ST_OK)
      else $error("error phase request made no output");

endmodule

`default_nettype wire

FILE: src/asd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module asd_fifo #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  asd_pkg::rec_type push_rec,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output asd_pkg::rec_type pop_rec
);
   import asd_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   rec_type              entries_ff [DEPTH];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_rec   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: src/asd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module asd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_valid,
   input  asd_pkg::rec_type queue_rec,
   output logic             queue_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output asd_pkg::rsp_type rsp_payload
);
   import asd_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] time_ff, time_in, base;

   assign queue_pop = queue_valid && (!rsp_valid_ff || rsp_ready);
   assign base      = queue_rec.restart ? 32'd0 : time_ff;

   always_comb begin
      rsp_in             = rsp_ff;
      time_in            = time_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      if (queue_pop) begin
         rsp_valid_in       = 1'b1;
         rsp_in.frame_byte  = queue_rec.data_byte;
         rsp_in.frame_start = queue_rec.frame_start;
         rsp_in.frame_end   = queue_rec.frame_end;
         rsp_in.frame_type  = queue_rec.frame_type;
         rsp_in.wideband    = queue_rec.wideband;
         rsp_in.time_ms     = queue_rec.stamped ? base : 32'd0;
         rsp_in.status      = queue_rec.status;
         // stamp advances once the closing byte of a frame is out
         time_in            = queue_rec.frame_end ? base + FRAME_MS : base;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         time_ff      <= 32'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_error_unstamped: assert property (@(posedge clock) disable iff (reset)
      queue_pop && !queue_rec.stamped
      |=> rsp_payload.time_ms == 32'd0 && rsp_payload.status != ST_OK)
      else $error("error output carries a time stamp");

   a_time_step: assert property (@(posedge clock) disable iff (reset)
      queue_pop && queue_rec.frame_end && !queue_rec.restart
      |=> time_ff == $past(time_ff) + FRAME_MS)
      else $error("time base did not advance by one frame");

endmodule

`default_nettype wire

FILE: src/amr_storage_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// req_      in         req_valid/req_ready    req_payload (data_byte, starts_file, ends_file)
// rsp_      out        rsp_valid/rsp_ready    rsp_payload (frame byte, marks, type, time, status)
//
// one request per cycle sustained while the queue is not full; the parser classifies a
// request as it is accepted and writes any output into the queue, the output register
// takes it from the queue when free, so rsp_valid rises after the queue and that register.
// the parser state advances once per accepted request, so that sets the rate.
// reset clears the parser, the queue and the time base; no clearing pass.
// a stalled rsp_ side fills the QUEUE_DEPTH-entry queue, then req_ready drops.
module amr_storage_deframer_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  asd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output asd_pkg::rsp_type rsp_payload
);
   import asd_pkg::*;

   logic    push, full, pop, not_empty;
   rec_type push_rec, pop_rec;

   asd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (full),
      .push        (push),
      .push_rec    (push_rec)
   );

   asd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_rec   (pop_rec)
   );

   asd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (not_empty),
      .queue_rec   (pop_rec),
      .queue_pop   (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
